[hw/rtl/eesd_pkg.sv]
// Shared types, constants and character helpers of the eexec stream decryptor.
package eesd_pkg;

  localparam int unsigned LEAD_BYTES = 4;
  localparam int unsigned LEAD_BUF   = (LEAD_BYTES < 2) ? 2 : LEAD_BYTES;
  localparam int unsigned LEAD_HALF  = LEAD_BYTES / 2;
  localparam int unsigned DISC_HEX   = LEAD_BYTES - LEAD_BYTES / 2;
  localparam int unsigned LCNT_W     = $clog2(LEAD_BYTES + 1);
  localparam int unsigned DISC_W     = $clog2(DISC_HEX + 1);
  localparam bit          LEAD_ODD   = (LEAD_BYTES % 2) != 0;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_SEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_MULT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ADD   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LEAD = 2'd3;

  localparam logic [15:0] KEY_SEED_RST = 16'd55665;
  localparam logic [15:0] KEY_MULT_RST = 16'd52845;
  localparam logic [15:0] KEY_ADD_RST  = 16'd22719;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       section_start;
  } eesd_in_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       hex_mode;
  } eesd_out_t;

  typedef struct packed {
    logic accept;
    logic drain;
  } eesd_cmd_t;

  typedef struct packed {
    logic              lead_done;
    logic              emit;
    logic [LCNT_W-1:0] drain_len;
  } eesd_sts_t;

  function automatic logic is_white(input logic [7:0] b);
    return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

  function automatic logic is_hexdig(input logic [7:0] b);
    return ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h41) && (b <= 8'h46)) ||
           ((b >= 8'h61) && (b <= 8'h66));
  endfunction

  function automatic logic [3:0] nib_of(input logic [7:0] b);
    logic [7:0] t;
    t = 8'h00;
    if ((b >= 8'h30) && (b <= 8'h39)) begin
      t = b - 8'h30;
    end else if ((b >= 8'h41) && (b <= 8'h46)) begin
      t = b - 8'h37;
    end else if ((b >= 8'h61) && (b <= 8'h66)) begin
      t = b - 8'h57;
    end
    return t[3:0];
  endfunction

endpackage

[hw/rtl/eesd_dp.sv]
// Datapath: configuration registers, key update, mode detection and result register.
module eesd_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [eesd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [eesd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  eesd_pkg::eesd_in_t                in_req_i,
  input  eesd_pkg::eesd_cmd_t               cmd_i,
  output eesd_pkg::eesd_sts_t               sts_o,
  output eesd_pkg::eesd_out_t               out_rsp_o
);
  import eesd_pkg::*;

  logic [15:0]             seed_q, mult_q, add_q;
  logic                    keep_q;
  logic [15:0]             key_q, key_d;
  logic [LEAD_BUF*8-1:0]   lead_q, lead_d;
  logic [LCNT_W-1:0]       lcnt_q, lcnt_d;
  logic                    hex_q, hex_d;
  logic [3:0]              hn_q, hn_d;
  logic                    pend_q, pend_d;
  logic [DISC_W-1:0]       disc_q, disc_d;
  eesd_out_t               out_q, out_d;

  logic                    ss;
  logic [LCNT_W-1:0]       lcnt_e;
  logic                    hex_e, pend_e;
  logic [3:0]              hn_e;
  logic [DISC_W-1:0]       disc_e;
  logic [15:0]             key_e;
  logic [7:0]              b;
  logic [7:0]              cin;
  logic                    dec;
  logic [15:0]             ksum;
  logic [15:0]             kprod;
  logic [15:0]             key_nxt;
  logic [7:0]              plain;
  logic                    lead_done, emit;

  assign b       = in_req_i.raw_byte;
  assign ss      = cmd_i.accept & in_req_i.section_start;
  assign lcnt_e  = ss ? '0 : lcnt_q;
  assign hex_e   = ss ? 1'b0 : hex_q;
  assign pend_e  = ss ? 1'b0 : pend_q;
  assign hn_e    = ss ? 4'h0 : hn_q;
  assign disc_e  = ss ? '0 : disc_q;
  assign key_e   = ss ? seed_q : key_q;

  assign ksum    = {8'h00, cin} + key_e;
  assign kprod   = ksum * mult_q;
  assign key_nxt = kprod + add_q;
  assign plain   = cin ^ key_e[15:8];

  always_comb begin
    key_d     = key_q;
    lead_d    = lead_q;
    lcnt_d    = lcnt_q;
    hex_d     = hex_q;
    hn_d      = hn_q;
    pend_d    = pend_q;
    disc_d    = disc_q;
    out_d     = out_q;
    cin       = b;
    dec       = 1'b0;
    lead_done = 1'b0;
    emit      = 1'b0;
    if (cmd_i.accept) begin
      key_d  = key_e;
      lcnt_d = lcnt_e;
      hex_d  = hex_e;
      hn_d   = hn_e;
      pend_d = pend_e;
      disc_d = disc_e;
      if (lcnt_e < LCNT_W'(LEAD_BYTES)) begin
        if (!((lcnt_e == '0) && is_white(b) && !keep_q)) begin
          lead_d = lead_q >> 8;
          lead_d[LEAD_BYTES*8-1 -: 8] = b;
          hex_d  = ((lcnt_e == '0) | hex_e) & is_hexdig(b);
          lcnt_d = lcnt_e + LCNT_W'(1);
          if (lcnt_e == LCNT_W'(LEAD_BYTES - 1)) begin
            lead_done = 1'b1;
            disc_d    = hex_d ? DISC_W'(DISC_HEX) : '0;
            if (LEAD_ODD && hex_d) begin
              hn_d   = nib_of(b);
              pend_d = 1'b1;
            end
          end
        end
      end else begin
        if (hex_e) begin
          if (!is_white(b)) begin
            if (!pend_e) begin
              hn_d   = nib_of(b);
              pend_d = 1'b1;
            end else begin
              cin    = {hn_e, nib_of(b)};
              pend_d = 1'b0;
              dec    = 1'b1;
            end
          end
        end else begin
          dec = 1'b1;
        end
        if (dec) begin
          key_d = key_nxt;
          if (disc_e != '0) begin
            disc_d = disc_e - DISC_W'(1);
          end else begin
            emit  = 1'b1;
            out_d = '{plain_byte: plain, hex_mode: hex_e};
          end
        end
      end
    end else if (cmd_i.drain) begin
      if (hex_q) begin
        cin    = {nib_of(lead_q[7:0]), nib_of(lead_q[15:8])};
        lead_d = lead_q >> 16;
      end else begin
        cin    = lead_q[7:0];
        lead_d = lead_q >> 8;
      end
      key_d = key_nxt;
    end
  end

  assign sts_o.lead_done = lead_done;
  assign sts_o.emit      = emit;
  assign sts_o.drain_len = hex_d ? LCNT_W'(LEAD_HALF) : LCNT_W'(LEAD_BYTES);
  assign out_rsp_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= KEY_SEED_RST;
      mult_q <= KEY_MULT_RST;
      add_q  <= KEY_ADD_RST;
      keep_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_KEY_SEED:  seed_q <= cfg_data_i;
        CFG_KEY_MULT:  mult_q <= cfg_data_i;
        CFG_KEY_ADD:   add_q  <= cfg_data_i;
        CFG_KEEP_LEAD: keep_q <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= KEY_SEED_RST;
      lcnt_q <= '0;
      hex_q  <= 1'b0;
      hn_q   <= 4'h0;
      pend_q <= 1'b0;
      disc_q <= '0;
    end else begin
      key_q  <= key_d;
      lcnt_q <= lcnt_d;
      hex_q  <= hex_d;
      hn_q   <= hn_d;
      pend_q <= pend_d;
      disc_q <= disc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lead_q <= lead_d;
    out_q  <= out_d;
  end

endmodule

[hw/rtl/eesd_ctrl.sv]
// Controller: handshakes, result register valid and lead-in key sequencing.
module eesd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  eesd_pkg::eesd_sts_t  sts_i,
  output eesd_pkg::eesd_cmd_t  cmd_o
);
  import eesd_pkg::*;

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic              state_q, state_d;
  logic [LCNT_W-1:0] cnt_q, cnt_d;
  logic              ovld_q, ovld_d;
  logic              accept;

  assign in_ready_o   = (state_q == ST_RUN) && (!ovld_q || out_ready_i);
  assign accept       = in_valid_i && in_ready_o;
  assign cmd_o.accept = accept;
  assign cmd_o.drain  = (state_q == ST_DRAIN);
  assign out_valid_o  = ovld_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ovld_d  = ovld_q;
    if (ovld_q && out_ready_i) begin
      ovld_d = 1'b0;
    end
    if (accept && sts_i.emit) begin
      ovld_d = 1'b1;
    end
    unique case (state_q)
      ST_RUN: begin
        if (accept && sts_i.lead_done && (sts_i.drain_len != '0)) begin
          state_d = ST_DRAIN;
          cnt_d   = sts_i.drain_len;
        end
      end
      ST_DRAIN: begin
        cnt_d = cnt_q - LCNT_W'(1);
        if (cnt_q == LCNT_W'(1)) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
    end
  end

`ifndef SYNTHESIS
  a_drain_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (cnt_q != '0))
    else $error("drain counter empty while draining");
  a_drain_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && sts_i.lead_done && (sts_i.drain_len != '0)) |=> (state_q == ST_DRAIN))
    else $error("lead-in completed without key sequencing");
  a_drain_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DRAIN) && (cnt_q == LCNT_W'(1))) |=> (state_q == ST_RUN))
    else $error("key sequencing overran");
  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && sts_i.emit) |=> ovld_q)
    else $error("result dropped");
`endif

endmodule

[hw/rtl/eexec_stream_decryptor.sv]
// Top level of the eexec stream decryptor: controller and datapath.
//
// Usage:
//   in channel  (in_valid_i/in_ready_o/in_req_i): one raw byte per request, with
//     section_start marking the first byte of a new encrypted section.
//   out channel (out_valid_o/out_ready_i/out_rsp_o): one plaintext byte and the
//     detected mode per request; hex-mode whitespace, hex high nibbles, lead-in
//     bytes and dropped plaintext produce no request.
//   cfg channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i): always ready;
//     write key seed, multiplier, addend and keep-leading-space while idle.
// Output: a result is registered and shows in the cycle after its byte is taken.
// Throughput: one byte per cycle while input is not held off, with the 16x16
//   multiply-add key update done combinationally. When the lead-in detection
//   completes, the shared key unit runs over the stored lead bytes (as hex pairs
//   in hex mode), and input is held off meanwhile.
// Reset: configuration returns to its defaults and the block behaves as if a
//   section had just started.
// Stall: a held result blocks a new byte only if that byte arrives while the
//   result register is full and out_ready_i is low.
module eexec_stream_decryptor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  eesd_pkg::eesd_in_t              in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output eesd_pkg::eesd_out_t             out_rsp_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [eesd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [eesd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import eesd_pkg::*;

  eesd_cmd_t cmd;
  eesd_sts_t sts;

  assign cfg_ready_o = 1'b1;

  eesd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  eesd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
